@@ hdl/rbd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbd_pkg
// Shared types and constants for the rotary encoder / button decoder.
// ----------------------------------------------------------------------------
package rbd_pkg;

	localparam int DEB_W    = 8;
	localparam int HOLD_W   = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [DEB_W-1:0]  DEB_RESET  = 8'd10;
	localparam logic [HOLD_W-1:0] LONG_RESET = 16'd1000;
	localparam logic [HOLD_W-1:0] HOLD_MAX   = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEBOUNCE   = 2'd0,
		CFG_LONG_PRESS = 2'd1
	} cfg_idx_t;

	typedef logic signed [1:0] rot_t;

	localparam rot_t ROT_NONE = 2'sd0;
	localparam rot_t ROT_CW   = 2'sd1;
	localparam rot_t ROT_CCW  = -2'sd1;

	typedef struct packed {
		logic press;
		logic long_press;
	} btn_evt_t;

endpackage
`default_nettype wire

@@ hdl/rotary_encoder_button_decoder.sv @@
// Path: an input transaction passes the input register, then the result
// register, before its result transaction appears.
// Throughput: one transaction per cycle; backpressure from the output
// register stalls the input register.
// Reset: all decoder state cleared; debounce_ticks = 10,
// long_press_ticks = 1000.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rotary_encoder_button_decoder
// Per-tick encoder step decode with debounced push button events.
// ----------------------------------------------------------------------------
module rotary_encoder_button_decoder (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic                            clk_level,
	input  wire logic                            dt_level,
	input  wire logic                            switch_level,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic signed [1:0]                    rotation,
	output logic                                 press_event,
	output logic                                 long_press_event,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [rbd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [rbd_pkg::CFG_DATA_W-1:0]  cfg_data
);

	logic [rbd_pkg::DEB_W-1:0]  debounce_ticks_q;
	logic [rbd_pkg::HOLD_W-1:0] long_press_ticks_q;

	logic valid_s1;
	logic clk_s1;
	logic dt_s1;
	logic sw_s1;
	logic adv;
	logic step;

	rbd_pkg::rot_t     rot_c;
	rbd_pkg::btn_evt_t evt_c;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ticks_q   <= rbd_pkg::DEB_RESET;
			long_press_ticks_q <= rbd_pkg::LONG_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				rbd_pkg::CFG_DEBOUNCE:
					debounce_ticks_q <= cfg_data[rbd_pkg::DEB_W-1:0];
				rbd_pkg::CFG_LONG_PRESS:
					long_press_ticks_q <= cfg_data[rbd_pkg::HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	assign adv      = !out_valid || out_ready;
	assign in_ready = !valid_s1 || adv;
	assign step     = valid_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			clk_s1 <= clk_level;
			dt_s1  <= dt_level;
			sw_s1  <= switch_level;
		end
	end

	rbd_rot u_rot (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.clk_level (clk_s1),
		.dt_level  (dt_s1),
		.rotation  (rot_c)
	);

	rbd_btn u_btn (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (step),
		.switch_level     (sw_s1),
		.debounce_ticks   (debounce_ticks_q),
		.long_press_ticks (long_press_ticks_q),
		.evt              (evt_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			rotation         <= rot_c;
			press_event      <= evt_c.press;
			long_press_event <= evt_c.long_press;
		end
	end

	a_evt_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(press_event && long_press_event))
		else $error("short and long press in the same result");

	a_rot_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (rotation != 2'sb10))
		else $error("invalid rotation code");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> valid_s1)
		else $error("stalled input stage dropped its transaction");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> out_valid)
		else $error("processed transaction not presented at output");

endmodule
`default_nettype wire

@@ hdl/rbd_rot.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbd_rot
// Encoder clock falling-edge detect; data line gives the direction.
// ----------------------------------------------------------------------------
module rbd_rot (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         step,
	input  wire logic         clk_level,
	input  wire logic         dt_level,
	output rbd_pkg::rot_t     rotation
);

	logic prev_clock_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_clock_q <= 1'b0;
		end else if (step) begin
			prev_clock_q <= clk_level;
		end
	end

	always_comb begin
		rotation = rbd_pkg::ROT_NONE;
		if (prev_clock_q && !clk_level) begin
			rotation = dt_level ? rbd_pkg::ROT_CW : rbd_pkg::ROT_CCW;
		end
	end

endmodule
`default_nettype wire

@@ hdl/rbd_btn.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbd_btn
// Switch debounce by run length, then press timing for short / long events.
// ----------------------------------------------------------------------------
module rbd_btn (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        step,
	input  wire logic                        switch_level,
	input  wire logic [rbd_pkg::DEB_W-1:0]   debounce_ticks,
	input  wire logic [rbd_pkg::HOLD_W-1:0]  long_press_ticks,
	output rbd_pkg::btn_evt_t                evt
);

	logic                       prev_raw_q;
	logic [rbd_pkg::DEB_W-1:0]  stable_count_q;
	logic                       debounced_q;
	logic                       held_q;
	logic                       long_done_q;
	logic [rbd_pkg::HOLD_W-1:0] held_count_q;

	logic                       raw;
	logic                       prev_raw_d;
	logic [rbd_pkg::DEB_W-1:0]  stable_count_d;
	logic                       debounced_d;
	logic                       held_d;
	logic                       long_done_d;
	logic [rbd_pkg::HOLD_W-1:0] held_count_d;
	logic [rbd_pkg::HOLD_W-1:0] held_inc;

	assign raw = ~switch_level;
	assign held_inc = (held_count_q != rbd_pkg::HOLD_MAX) ?
		held_count_q + rbd_pkg::HOLD_W'(1) : held_count_q;

	always_comb begin
		prev_raw_d     = prev_raw_q;
		stable_count_d = stable_count_q;
		debounced_d    = debounced_q;
		if (raw == prev_raw_q) begin
			if (stable_count_q < debounce_ticks) begin
				stable_count_d = stable_count_q + rbd_pkg::DEB_W'(1);
				if (stable_count_d == debounce_ticks) begin
					debounced_d = raw;
				end
			end
		end else begin
			prev_raw_d     = raw;
			stable_count_d = '0;
		end
	end

	always_comb begin
		held_d       = held_q;
		long_done_d  = long_done_q;
		held_count_d = held_count_q;
		evt          = '0;
		if (debounced_d && !held_q) begin
			held_d       = 1'b1;
			long_done_d  = 1'b0;
			held_count_d = '0;
		end else if (debounced_d && !long_done_q) begin
			held_count_d = held_inc;
			if (held_inc >= long_press_ticks) begin
				evt.long_press = 1'b1;
				long_done_d    = 1'b1;
			end
		end else if (!debounced_d && held_q) begin
			evt.press = ~long_done_q;
			held_d    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_raw_q     <= 1'b0;
			stable_count_q <= '0;
			debounced_q    <= 1'b0;
			held_q         <= 1'b0;
			long_done_q    <= 1'b0;
			held_count_q   <= '0;
		end else if (step) begin
			prev_raw_q     <= prev_raw_d;
			stable_count_q <= stable_count_d;
			debounced_q    <= debounced_d;
			held_q         <= held_d;
			long_done_q    <= long_done_d;
			held_count_q   <= held_count_d;
		end
	end

endmodule
`default_nettype wire
